>>> sv/twe_pkg.sv
// Shared types, widths and codes for the timer wheel expiry block.
package twe_pkg;

   // Fixed field widths
   localparam int MODE_W      = 2;
   localparam int ID_W        = 5;
   localparam int TIMEOUT_W   = 16;
   localparam int KIND_W      = 2;
   localparam int SLOT_OUT_W  = 6;
   localparam int INTERVAL_W  = 8;
   localparam int SIU_W       = 7;
   localparam int CSR_DATA_W  = 8;
   localparam int CSR_INDEX_W = 1;

   // Divider: dividend holds current slot + 16-bit tick count, divisor fits 8 bits
   localparam int DIV_W  = 17;
   localparam int DVSR_W = 8;

   // At most this many expiries are reported per tick
   localparam int RESULT_CAP = 32;
   localparam int CNT_W      = $clog2(RESULT_CAP + 1);

   // Parameter defaults
   localparam int DEF_POOL_ENTRIES = 32;
   localparam int DEF_MAX_SLOTS    = 64;

   // Register reset values
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd1;
   localparam logic [SIU_W-1:0]      SIU_RESET      = 7'd64;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_PERIOD  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOTS_IN_USE = 1'd1;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_ADD        = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EXPIRED    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NO_EXPIRY  = 2'd3;

   // Result status
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_TICKS,
      ST_DIV_TARGET,
      ST_ADD_OUT,
      ST_REM_OUT,
      ST_TICK_DIV,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      DIVOP_TICKS,
      DIVOP_TARGET,
      DIVOP_TICK
   } div_op_type;

   typedef enum logic [1:0] {
      OUT_ADD,
      OUT_REM,
      OUT_MID,
      OUT_FINAL
   } out_sel_type;

   typedef enum logic [1:0] {
      RA_REQ,
      RA_ID,
      RA_SCAN
   } raddr_sel_type;

   typedef struct packed {
      logic          accept;
      logic          div_start;
      div_op_type    div_op;
      logic          cur_load;
      logic          scan_init;
      logic          scan_adv;
      logic          scan_capture;
      logic          out_load;
      out_sel_type   out_sel;
      raddr_sel_type raddr_sel;
   } cmd_type;

   typedef struct packed {
      logic req_id_ok;
      logic div_done;
      logic out_free;
      logic match;
      logic pend_valid;
      logic scan_at_end;
      logic cap_next;
   } stat_type;

endpackage

>>> sv/twe_ifs.sv
// Request and response channel interfaces of the timer wheel expiry block.
interface twe_req_if import twe_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [MODE_W-1:0]    mode;
   logic [ID_W-1:0]      timer_id;
   logic [TIMEOUT_W-1:0] delay_secs;

   modport source (output valid, output mode, output timer_id, output delay_secs,
                   input ready);
   modport sink (input valid, input mode, input timer_id, input delay_secs,
                 output ready);
endinterface

interface twe_rsp_if import twe_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [KIND_W-1:0]     kind;
   logic [ID_W-1:0]       entry_id;
   logic [SLOT_OUT_W-1:0] slot_index;
   logic                  status;
   logic                  last;

   modport source (output valid, output kind, output entry_id, output slot_index,
                   output status, output last, input ready);
   modport sink (input valid, input kind, input entry_id, input slot_index,
                 input status, input last, output ready);
endinterface

>>> sv/twe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module twe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/twe_div.sv
// Restoring divider, one quotient bit per cycle, gives quotient and remainder.
module twe_div import twe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [DVSR_W-1:0] divisor,
   output logic              done,
   output logic [DIV_W-1:0]  quotient,
   output logic [DVSR_W-1:0] remainder
);

   localparam int CW = $clog2(DIV_W);

   logic              busy_ff;
   logic              done_ff;
   logic [CW-1:0]     cnt_ff;
   logic [DIV_W-1:0]  quo_ff;
   logic [DVSR_W-1:0] rem_ff;
   logic [DVSR_W-1:0] dvsr_ff;

   logic [DVSR_W:0]   trial;
   logic [DVSR_W:0]   diff;
   logic              fits;
   logic              last_step;

   assign trial     = {rem_ff, quo_ff[DIV_W-1]};
   assign diff      = trial - {1'b0, dvsr_ff};
   assign fits      = (trial >= {1'b0, dvsr_ff});
   assign last_step = (cnt_ff == CW'(DIV_W - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && last_step && !start;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (last_step) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Shift the dividend out at the top, quotient bits in at the bottom
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff  <= dividend;
         rem_ff  <= '0;
         dvsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
         rem_ff <= fits ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

>>> sv/twe_datapath.sv
// Datapath: registers, armed bits, slot memory, divider, scan and result register.
module twe_datapath import twe_pkg::*; #(
   parameter int POOL_ENTRIES = DEF_POOL_ENTRIES,
   parameter int MAX_SLOTS    = DEF_MAX_SLOTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [ID_W-1:0]        req_timer_id,
   input  logic [TIMEOUT_W-1:0]   req_delay_secs,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [KIND_W-1:0]      rsp_kind,
   output logic [ID_W-1:0]        rsp_entry_id,
   output logic [SLOT_OUT_W-1:0]  rsp_slot_index,
   output logic                   rsp_status,
   output logic                   rsp_last
);

   localparam int IW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
   localparam int SW = $clog2(MAX_SLOTS);

   logic [INTERVAL_W-1:0] slot_period_ff;
   logic [SIU_W-1:0]      slots_in_use_ff;
   logic [SW-1:0]         cur_ff;
   logic [POOL_ENTRIES-1:0] armed_ff;
   logic [ID_W-1:0]       id_ff;
   logic                  id_ok_ff;
   logic [IW-1:0]         idx_ff;
   logic [IW-1:0]         pend_ff;
   logic                  pend_valid_ff;
   logic [CNT_W-1:0]      cnt_ff;

   logic                  out_valid_ff;
   logic [KIND_W-1:0]     out_kind_ff;
   logic [ID_W-1:0]       out_id_ff;
   logic [SLOT_OUT_W-1:0] out_slot_ff;
   logic                  out_status_ff;
   logic                  out_last_ff;

   logic [DVSR_W-1:0]     iv_eff;
   logic [DVSR_W-1:0]     m_eff;
   logic [DIV_W-1:0]      div_dividend;
   logic [DVSR_W-1:0]     div_divisor;
   logic                  div_done;
   logic [DIV_W-1:0]      div_quo;
   logic [DVSR_W-1:0]     div_rem;
   logic [TIMEOUT_W-1:0]  ticks;
   logic [SW-1:0]         div_slot;

   logic                  ram_we;
   logic [IW-1:0]         ram_raddr;
   logic [SW-1:0]         ram_rdata;

   logic                  id_in_pool;
   logic                  at_end;
   logic                  match;
   logic                  rem_ok;
   logic                  out_free;
   logic                  add_commit;
   logic                  rem_commit;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_period_ff  <= INTERVAL_RESET;
         slots_in_use_ff <= SIU_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SLOT_PERIOD:  slot_period_ff  <= csr_wdata[INTERVAL_W-1:0];
            CSR_SLOTS_IN_USE: slots_in_use_ff <= csr_wdata[SIU_W-1:0];
            default: ;
         endcase
      end
   end

   // Zero interval acts as one; wheel size clamped to 1 .. MAX_SLOTS
   assign iv_eff = (slot_period_ff == '0) ? DVSR_W'(1) : DVSR_W'(slot_period_ff);

   always_comb begin
      if (slots_in_use_ff == '0) begin
         m_eff = DVSR_W'(1);
      end else if (int'(slots_in_use_ff) > MAX_SLOTS) begin
         m_eff = DVSR_W'(MAX_SLOTS);
      end else begin
         m_eff = DVSR_W'(slots_in_use_ff);
      end
   end

   assign ticks    = (div_quo[TIMEOUT_W-1:0] == '0) ? TIMEOUT_W'(1) : div_quo[TIMEOUT_W-1:0];
   assign div_slot = SW'(div_rem);

   always_comb begin
      unique case (cmd.div_op)
         DIVOP_TICKS: begin
            div_dividend = DIV_W'(req_delay_secs);
            div_divisor  = iv_eff;
         end
         DIVOP_TARGET: begin
            div_dividend = DIV_W'(cur_ff) + DIV_W'(ticks);
            div_divisor  = m_eff;
         end
         DIVOP_TICK: begin
            div_dividend = DIV_W'(cur_ff) + DIV_W'(1);
            div_divisor  = m_eff;
         end
         default: begin
            div_dividend = '0;
            div_divisor  = m_eff;
         end
      endcase
   end

   twe_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Slot of each armed entry
   assign add_commit = cmd.out_load && (cmd.out_sel == OUT_ADD) && id_ok_ff;
   assign rem_commit = cmd.out_load && (cmd.out_sel == OUT_REM) && rem_ok;
   assign ram_we     = add_commit;
   assign at_end     = (idx_ff == IW'(POOL_ENTRIES - 1));

   always_comb begin
      unique case (cmd.raddr_sel)
         RA_REQ:  ram_raddr = IW'(req_timer_id);
         RA_ID:   ram_raddr = IW'(id_ff);
         RA_SCAN: ram_raddr = (cmd.scan_adv && !at_end) ? idx_ff + 1'b1 : idx_ff;
         default: ram_raddr = idx_ff;
      endcase
   end

   twe_ram #(
      .WIDTH (SW),
      .DEPTH (POOL_ENTRIES)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (IW'(id_ff)),
      .wdata (div_slot),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign id_in_pool = (int'(req_timer_id) < POOL_ENTRIES);
   assign match      = armed_ff[idx_ff] && (ram_rdata == cur_ff);
   assign rem_ok     = id_ok_ff && armed_ff[IW'(id_ff)];
   assign out_free   = !out_valid_ff || rsp_ready;

   // Latched request id
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         id_ff    <= req_timer_id;
         id_ok_ff <= id_in_pool;
      end
   end

   // Armed bits and current slot
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= '0;
         cur_ff   <= '0;
      end else begin
         if (add_commit) begin
            armed_ff[IW'(id_ff)] <= 1'b1;
         end
         if (rem_commit) begin
            armed_ff[IW'(id_ff)] <= 1'b0;
         end
         if (cmd.scan_capture) begin
            armed_ff[idx_ff] <= 1'b0;
         end
         if (cmd.cur_load) begin
            cur_ff <= div_slot;
         end
      end
   end

   // Scan index, one pending match held back to mark the last
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         cnt_ff        <= '0;
      end else if (cmd.scan_init) begin
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         if (cmd.scan_adv) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.scan_capture) begin
            pend_valid_ff <= 1'b1;
            cnt_ff        <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_capture) begin
         pend_ff <= idx_ff;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         unique case (cmd.out_sel)
            OUT_ADD: begin
               out_kind_ff   <= KIND_ADD;
               out_id_ff     <= id_ff;
               out_slot_ff   <= id_ok_ff ? SLOT_OUT_W'(div_slot) : '0;
               out_status_ff <= id_ok_ff ? STATUS_OK : STATUS_FAIL;
               out_last_ff   <= 1'b1;
            end
            OUT_REM: begin
               out_kind_ff   <= KIND_REMOVE;
               out_id_ff     <= id_ff;
               out_slot_ff   <= rem_ok ? SLOT_OUT_W'(ram_rdata) : '0;
               out_status_ff <= rem_ok ? STATUS_OK : STATUS_FAIL;
               out_last_ff   <= 1'b1;
            end
            OUT_MID: begin
               out_kind_ff   <= KIND_EXPIRED;
               out_id_ff     <= ID_W'(pend_ff);
               out_slot_ff   <= SLOT_OUT_W'(cur_ff);
               out_status_ff <= STATUS_OK;
               out_last_ff   <= 1'b0;
            end
            OUT_FINAL: begin
               out_kind_ff   <= pend_valid_ff ? KIND_EXPIRED : KIND_NO_EXPIRY;
               out_id_ff     <= pend_valid_ff ? ID_W'(pend_ff) : '0;
               out_slot_ff   <= SLOT_OUT_W'(cur_ff);
               out_status_ff <= STATUS_OK;
               out_last_ff   <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = out_kind_ff;
   assign rsp_entry_id   = out_id_ff;
   assign rsp_slot_index = out_slot_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_last       = out_last_ff;

   assign stat.req_id_ok   = id_in_pool;
   assign stat.div_done    = div_done;
   assign stat.out_free    = out_free;
   assign stat.match       = match;
   assign stat.pend_valid  = pend_valid_ff;
   assign stat.scan_at_end = at_end;
   assign stat.cap_next    = (cnt_ff == CNT_W'(RESULT_CAP - 1));

   a_cap_bound: assert property (@(posedge clock) disable iff (reset)
      int'(cnt_ff) <= RESULT_CAP)
      else $error("expiry count beyond cap");

   a_capture_armed: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_capture |-> armed_ff[idx_ff])
      else $error("captured an entry that was not armed");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("result register overwritten while held");

   a_cur_in_wheel: assert property (@(posedge clock) disable iff (reset)
      cmd.cur_load |=> (int'(cur_ff) < int'(m_eff)))
      else $error("current slot outside wheel");

endmodule

>>> sv/twe_ctrl.sv
// Controller state machine sequencing add, remove and tick transactions.
module twe_ctrl import twe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [MODE_W-1:0] req_mode,
   output logic              req_ready,
   input  stat_type          stat,
   output cmd_type           cmd
);

   state_type state_ff;
   state_type state_in;
   logic      stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold the scan when a match arrives while one is pending and the result register is busy
   assign stall = stat.match && stat.pend_valid && !stat.out_free;

   always_comb begin
      state_in         = state_ff;
      req_ready        = 1'b0;
      cmd.accept       = 1'b0;
      cmd.div_start    = 1'b0;
      cmd.div_op       = DIVOP_TICKS;
      cmd.cur_load     = 1'b0;
      cmd.scan_init    = 1'b0;
      cmd.scan_adv     = 1'b0;
      cmd.scan_capture = 1'b0;
      cmd.out_load     = 1'b0;
      cmd.out_sel      = OUT_ADD;
      cmd.raddr_sel    = RA_SCAN;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.raddr_sel = RA_REQ;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_mode == MODE_ADD) begin
                  if (stat.req_id_ok) begin
                     cmd.div_start = 1'b1;
                     cmd.div_op    = DIVOP_TICKS;
                     state_in      = ST_DIV_TICKS;
                  end else begin
                     state_in = ST_ADD_OUT;
                  end
               end else if (req_mode == MODE_REMOVE) begin
                  state_in = ST_REM_OUT;
               end else if (req_mode == MODE_TICK) begin
                  cmd.div_start = 1'b1;
                  cmd.div_op    = DIVOP_TICK;
                  cmd.scan_init = 1'b1;
                  state_in      = ST_TICK_DIV;
               end
            end
         end
         ST_DIV_TICKS: begin
            if (stat.div_done) begin
               cmd.div_start = 1'b1;
               cmd.div_op    = DIVOP_TARGET;
               state_in      = ST_DIV_TARGET;
            end
         end
         ST_DIV_TARGET: begin
            cmd.div_op = DIVOP_TARGET;
            if (stat.div_done) begin
               state_in = ST_ADD_OUT;
            end
         end
         ST_ADD_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_ADD;
               state_in     = ST_IDLE;
            end
         end
         ST_REM_OUT: begin
            cmd.raddr_sel = RA_ID;
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_REM;
               state_in     = ST_IDLE;
            end
         end
         ST_TICK_DIV: begin
            cmd.div_op = DIVOP_TICK;
            if (stat.div_done) begin
               cmd.cur_load = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               cmd.scan_adv = 1'b1;
               if (stat.match) begin
                  cmd.scan_capture = 1'b1;
                  if (stat.pend_valid) begin
                     cmd.out_load = 1'b1;
                     cmd.out_sel  = OUT_MID;
                  end
               end
               if (stat.scan_at_end || (stat.match && stat.cap_next)) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_FINAL;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> sv/timer_wheel_expiry.sv
// Top level of the timer wheel expiry block: hashed timing wheel over a pool of timers.
//
// Usage:
//   req_chan (sink) carries one transaction per operation: mode add, remove or tick,
//   plus timer_id and delay_secs. rsp_chan (source) returns results with kind,
//   entry_id, slot_index, status and last; last marks the final result of a request.
//   csr_we/csr_index/csr_wdata write the slot period (index 0) and slots_in_use
//   (index 1); write them only while the block is idle.
// Timing:
//   Add: for an id within the pool, two passes of the bit-serial divider
//   (timeout / interval, then the slot modulo) before the result is loaded.
//   Remove: no divider pass; the slot comes from the registered read of the slot memory.
//   Tick: a modulo pass of the divider, then a scan of one pool entry per cycle
//   while the scan does not stall; up to 32 results.
//   One request in flight: the next is taken the cycle after the last result is
//   loaded, even while it waits.
// Reset: synchronous, active high; current slot 0, nothing armed, interval 1,
//   64 slots. The slot memory needs no clearing pass.
// Stall: while rsp_chan is not ready, the result register holds and the scan
//   waits at the next matching entry; nothing is dropped.
module timer_wheel_expiry import twe_pkg::*; #(
   parameter int POOL_ENTRIES = DEF_POOL_ENTRIES,
   parameter int MAX_SLOTS    = DEF_MAX_SLOTS
) (
   input  logic                   clock,
   input  logic                   reset,
   twe_req_if.sink                req_chan,
   twe_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   // Sequence each transaction
   twe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   assign req_chan.ready = req_ready;

   // Hold the wheel state and drive the result register
   twe_datapath #(
      .POOL_ENTRIES (POOL_ENTRIES),
      .MAX_SLOTS    (MAX_SLOTS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_timer_id    (req_chan.timer_id),
      .req_delay_secs  (req_chan.delay_secs),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_kind        (rsp_chan.kind),
      .rsp_entry_id    (rsp_chan.entry_id),
      .rsp_slot_index  (rsp_chan.slot_index),
      .rsp_status      (rsp_chan.status),
      .rsp_last        (rsp_chan.last)
   );

endmodule
